@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, idle during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Same-cycle implication, checked during reset as well
`define ASSERT_PLAIN(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/asat_pkg.sv @@
package asat_pkg;

   // Default table depths
   localparam int PtrEntriesDefault  = 1024;
   localparam int SiteEntriesDefault = 256;

   // Field widths
   localparam int FuncW    = 2;
   localparam int AddrW    = 64;
   localparam int SizeW    = 40;
   localparam int HashW    = 64;
   localparam int SlotW    = 8;
   localparam int StatW    = 3;
   localparam int TotalW   = 48;
   localparam int ReqDataW = 176;
   localparam int RspDataW = 152;

   // Function codes
   localparam logic [FuncW-1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [FuncW-1:0] FUNC_FREE   = 2'd1;
   localparam logic [FuncW-1:0] FUNC_REPORT = 2'd2;

   // Status codes
   localparam logic [StatW-1:0] STATUS_RECORDED = 3'd0;
   localparam logic [StatW-1:0] STATUS_DUP      = 3'd1;
   localparam logic [StatW-1:0] STATUS_RELEASED = 3'd2;
   localparam logic [StatW-1:0] STATUS_UNKNOWN  = 3'd3;
   localparam logic [StatW-1:0] STATUS_FULL     = 3'd4;
   localparam logic [StatW-1:0] STATUS_VALID    = 3'd5;
   localparam logic [StatW-1:0] STATUS_EMPTY    = 3'd6;

   // Site table word
   typedef struct packed {
      logic              valid;
      logic [HashW-1:0]  key;
      logic [TotalW-1:0] bytes;
   } site_entry_type;

   localparam int SiteWordW = $bits(site_entry_type);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_PSCAN,
      ST_PDONE,
      ST_SSCAN,
      ST_SDONE,
      ST_SRD,
      ST_SDAT,
      ST_EMPTY,
      ST_UNKNOWN,
      ST_COMMIT
   } state_type;

   typedef enum logic [2:0] {
      RES_EMPTY,
      RES_UNKNOWN,
      RES_REPORT,
      RES_DUP,
      RES_RELEASE,
      RES_RECORD
   } res_op_type;

   // Controller to datapath
   typedef struct packed {
      logic       clr;
      logic       load_item;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       ptr_scan;
      logic       site_scan;
      logic       site_rd;
      logic       res_load;
      res_op_type res_op;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic             clr_last;
      logic             ptr_last;
      logic             site_last;
      logic             p_hit;
      logic             slot_ok;
      logic             out_free;
      logic [FuncW-1:0] func;
   } sts_type;

endpackage

@@ hw/rtl/asat_ram.sv @@
module asat_ram import asat_pkg::*; #(
   parameter int WIDTH = SiteWordW,
   parameter int DEPTH = SiteEntriesDefault
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/asat_ctrl.sv @@
module asat_ctrl import asat_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.res_op = RES_EMPTY;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr     = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               cmd.cnt_clr   = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (sts.func)
               FUNC_ALLOC, FUNC_FREE: state_in = ST_PSCAN;
               FUNC_REPORT:           state_in = sts.slot_ok ? ST_SRD : ST_EMPTY;
               default:               state_in = ST_IDLE;
            endcase
         end
         ST_PSCAN: begin
            cmd.ptr_scan = 1'b1;
            cmd.cnt_inc  = 1'b1;
            if (sts.ptr_last) state_in = ST_PDONE;
         end
         ST_PDONE: begin
            cmd.cnt_clr = 1'b1;
            if (sts.p_hit) begin
               state_in = ST_SRD;
            end else if (sts.func == FUNC_ALLOC) begin
               state_in = ST_SSCAN;
            end else begin
               state_in = ST_UNKNOWN;
            end
         end
         ST_SSCAN: begin
            cmd.site_scan = 1'b1;
            cmd.cnt_inc   = 1'b1;
            if (sts.site_last) state_in = ST_SDONE;
         end
         ST_SDONE: begin
            state_in = ST_COMMIT;
         end
         ST_SRD: begin
            cmd.site_rd = 1'b1;
            state_in    = ST_SDAT;
         end
         ST_SDAT: begin
            unique case (sts.func)
               FUNC_ALLOC: cmd.res_op = RES_DUP;
               FUNC_FREE:  cmd.res_op = RES_RELEASE;
               default:    cmd.res_op = RES_REPORT;
            endcase
            if (sts.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            cmd.res_op = RES_EMPTY;
            if (sts.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_UNKNOWN: begin
            cmd.res_op = RES_UNKNOWN;
            if (sts.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_COMMIT: begin
            cmd.res_op = RES_RECORD;
            if (sts.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/asat_dp.sv @@
module asat_dp import asat_pkg::*; #(
   parameter int PTR_ENTRIES  = PtrEntriesDefault,
   parameter int SITE_ENTRIES = SiteEntriesDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [FuncW-1:0]    req_func,
   input  logic [AddrW-1:0]    req_address,
   input  logic [SizeW-1:0]    req_byte_count,
   input  logic [HashW-1:0]    req_site_hash,
   input  logic [SlotW-1:0]    req_slot_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [StatW-1:0]    rsp_status,
   output logic [HashW-1:0]    rsp_site_out,
   output logic [TotalW-1:0]   rsp_site_total,
   output logic [SizeW-1:0]    rsp_released_size
);

   localparam int PW       = $clog2(PTR_ENTRIES);
   localparam int SW       = $clog2(SITE_ENTRIES);
   localparam int MaxEnt   = (PTR_ENTRIES > SITE_ENTRIES) ? PTR_ENTRIES : SITE_ENTRIES;
   localparam int CW       = $clog2(MaxEnt) + 1;
   // pointer word: valid, key, size, site slot from bit 0 up
   localparam int PKeyLo   = 1;
   localparam int PSizeLo  = PKeyLo + AddrW;
   localparam int PSlotLo  = PSizeLo + SizeW;
   localparam int PtrWordW = PSlotLo + SW;

   // Item registers
   logic [FuncW-1:0] func_ff;
   logic [AddrW-1:0] addr_ff;
   logic [SizeW-1:0] size_ff;
   logic [HashW-1:0] hash_ff;
   logic [SlotW-1:0] slot_ff;

   // Scan control
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rd_idx_ff;
   logic          rd_vld_ff, rd_vld_in;

   // Scan findings
   logic              p_hit_ff, p_free_ok_ff, s_hit_ff, s_free_ok_ff;
   logic [PW-1:0]     p_idx_ff, p_free_ff;
   logic [SizeW-1:0]  p_size_ff;
   logic [SW-1:0]     p_slot_ff, s_idx_ff, s_free_ff;
   logic [TotalW-1:0] s_bytes_ff;

   // Memory ports
   logic                ptr_we, ptr_re, site_we, site_re;
   logic [PW-1:0]       ptr_waddr;
   logic [SW-1:0]       site_waddr, site_raddr;
   logic [PtrWordW-1:0] ptr_wdata, ptr_rdata;
   site_entry_type      site_wdata, site_rdata;

   // Result register
   logic              rsp_vld_ff, rsp_vld_in;
   logic [StatW-1:0]  stat_ff, stat_in;
   logic [HashW-1:0]  site_out_ff, site_out_in;
   logic [TotalW-1:0] total_ff, total_in;
   logic [SizeW-1:0]  rel_ff, rel_in;

   logic              issue_p, issue_s, full;
   logic [TotalW:0]   rec_sum;
   logic [TotalW-1:0] rec_total, rel_total;
   logic [SW-1:0]     rec_slot, slot_addr;
   logic [PW-1:0]     rd_pidx;
   logic [SW-1:0]     rd_sidx;
   logic              p_match, s_match;

   asat_ram #(.WIDTH(PtrWordW), .DEPTH(PTR_ENTRIES)) u_ptr_ram (
      .clock (clock),
      .we    (ptr_we),
      .waddr (ptr_waddr),
      .wdata (ptr_wdata),
      .re    (ptr_re),
      .raddr (cnt_ff[PW-1:0]),
      .rdata (ptr_rdata)
   );

   asat_ram #(.WIDTH(SiteWordW), .DEPTH(SITE_ENTRIES)) u_site_ram (
      .clock (clock),
      .we    (site_we),
      .waddr (site_waddr),
      .wdata (site_wdata),
      .re    (site_re),
      .raddr (site_raddr),
      .rdata (site_rdata)
   );

   // Counter and read issue
   always_comb begin
      issue_p   = cmd.ptr_scan && (32'(cnt_ff) < PTR_ENTRIES);
      issue_s   = cmd.site_scan && (32'(cnt_ff) < SITE_ENTRIES);
      rd_vld_in = issue_p || issue_s;
      ptr_re    = issue_p;
      site_re   = issue_s || cmd.site_rd;
      slot_addr = SW'(slot_ff);
      if (cmd.site_rd) begin
         site_raddr = (func_ff == FUNC_REPORT) ? slot_addr : p_slot_ff;
      end else begin
         site_raddr = cnt_ff[SW-1:0];
      end
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
      rd_pidx = rd_idx_ff[PW-1:0];
      rd_sidx = rd_idx_ff[SW-1:0];
      p_match = rd_vld_ff && ptr_rdata[0] && (ptr_rdata[PSizeLo-1:PKeyLo] == addr_ff);
      s_match = rd_vld_ff && site_rdata.valid && (site_rdata.key == hash_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_vld_in;
      end
      rd_idx_ff <= cnt_ff;
   end

   // Item capture and scan bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff      <= req_func;
         addr_ff      <= req_address;
         size_ff      <= req_byte_count;
         hash_ff      <= req_site_hash;
         slot_ff      <= req_slot_index;
         p_hit_ff     <= 1'b0;
         p_free_ok_ff <= 1'b0;
         s_hit_ff     <= 1'b0;
         s_free_ok_ff <= 1'b0;
      end else if (cmd.ptr_scan && rd_vld_ff) begin
         if (p_match && !p_hit_ff) begin
            p_hit_ff  <= 1'b1;
            p_idx_ff  <= rd_pidx;
            p_size_ff <= ptr_rdata[PSlotLo-1:PSizeLo];
            p_slot_ff <= ptr_rdata[PtrWordW-1:PSlotLo];
         end
         if (!ptr_rdata[0] && !p_free_ok_ff) begin
            p_free_ok_ff <= 1'b1;
            p_free_ff    <= rd_pidx;
         end
      end else if (cmd.site_scan && rd_vld_ff) begin
         if (s_match && !s_hit_ff) begin
            s_hit_ff   <= 1'b1;
            s_idx_ff   <= rd_sidx;
            s_bytes_ff <= site_rdata.bytes;
         end
         if (!site_rdata.valid && !s_free_ok_ff) begin
            s_free_ok_ff <= 1'b1;
            s_free_ff    <= rd_sidx;
         end
      end
   end

   // Result and table updates
   always_comb begin
      full      = !p_free_ok_ff || (!s_hit_ff && !s_free_ok_ff);
      rec_sum   = {1'b0, (s_hit_ff ? s_bytes_ff : '0)} + (TotalW+1)'(size_ff);
      rec_total = rec_sum[TotalW] ? '1 : rec_sum[TotalW-1:0];
      rec_slot  = s_hit_ff ? s_idx_ff : s_free_ff;
      rel_total = (site_rdata.bytes > TotalW'(p_size_ff)) ?
                  site_rdata.bytes - TotalW'(p_size_ff) : '0;

      stat_in     = STATUS_EMPTY;
      site_out_in = '0;
      total_in    = '0;
      rel_in      = '0;
      ptr_we      = 1'b0;
      ptr_waddr   = p_idx_ff;
      ptr_wdata   = '0;
      site_we     = 1'b0;
      site_waddr  = p_slot_ff;
      site_wdata  = '{valid: 1'b1, key: site_rdata.key, bytes: rel_total};

      if (cmd.clr) begin
         ptr_we     = 32'(cnt_ff) < PTR_ENTRIES;
         ptr_waddr  = cnt_ff[PW-1:0];
         site_we    = 32'(cnt_ff) < SITE_ENTRIES;
         site_waddr = cnt_ff[SW-1:0];
         site_wdata = '0;
      end

      case (cmd.res_op)
         RES_REPORT: begin
            stat_in     = site_rdata.valid ? STATUS_VALID : STATUS_EMPTY;
            site_out_in = site_rdata.valid ? site_rdata.key : '0;
            total_in    = site_rdata.valid ? site_rdata.bytes : '0;
         end
         RES_UNKNOWN: begin
            stat_in = STATUS_UNKNOWN;
         end
         RES_DUP: begin
            stat_in     = STATUS_DUP;
            site_out_in = site_rdata.key;
            total_in    = site_rdata.bytes;
         end
         RES_RELEASE: begin
            stat_in     = STATUS_RELEASED;
            site_out_in = site_rdata.key;
            total_in    = rel_total;
            rel_in      = p_size_ff;
            ptr_we      = cmd.res_load;
            site_we     = cmd.res_load;
         end
         RES_RECORD: begin
            site_out_in = hash_ff;
            if (full) begin
               stat_in  = STATUS_FULL;
               total_in = s_hit_ff ? s_bytes_ff : '0;
            end else begin
               stat_in    = STATUS_RECORDED;
               total_in   = rec_total;
               ptr_we     = cmd.res_load;
               ptr_waddr  = p_free_ff;
               ptr_wdata  = {rec_slot, size_ff, addr_ff, 1'b1};
               site_we    = cmd.res_load;
               site_waddr = rec_slot;
               site_wdata = '{valid: 1'b1, key: hash_ff, bytes: rec_total};
            end
         end
         default: begin
            stat_in = STATUS_EMPTY;
         end
      endcase

      if (cmd.res_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (cmd.res_load) begin
         stat_ff     <= stat_in;
         site_out_ff <= site_out_in;
         total_ff    <= total_in;
         rel_ff      <= rel_in;
      end
   end

   // Status to controller
   always_comb begin
      sts.clr_last  = (32'(cnt_ff) == MaxEnt - 1);
      sts.ptr_last  = rd_vld_ff && (32'(rd_idx_ff) == PTR_ENTRIES - 1);
      sts.site_last = rd_vld_ff && (32'(rd_idx_ff) == SITE_ENTRIES - 1);
      sts.p_hit     = p_hit_ff;
      sts.slot_ok   = 32'(slot_ff) < SITE_ENTRIES;
      sts.out_free  = !rsp_vld_ff || rsp_ready;
      sts.func      = func_ff;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_status        = stat_ff;
   assign rsp_site_out      = site_out_ff;
   assign rsp_site_total    = total_ff;
   assign rsp_released_size = rel_ff;

endmodule

@@ hw/rtl/allocation_site_accounting_table.sv @@
// Channel  Dir  tdata (low bit up)                              tuser
// req      in   address[63:0] byte_count[103:64]                func[1:0]
//               site_hash[167:104] slot_index[175:168]
// rsp      out  site_out[63:0] site_total[111:64]               status[2:0]
//               released_size[151:112]
//
// After reset a clearing pass over max(PTR_ENTRIES, SITE_ENTRIES) entries runs; no
// transfer is taken on req until it ends.
// A report reads its site slot directly. A release searches the pointer table, and a
// new allocation searches the pointer table and then the site table; both searches
// run linearly through each table RAM, one entry per cycle on its single read port.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken, and rsp stalls hold the last step.
module allocation_site_accounting_table import asat_pkg::*; #(
   parameter int PTR_ENTRIES  = PtrEntriesDefault,
   parameter int SITE_ENTRIES = SiteEntriesDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // address, byte_count, site_hash, slot_index
   input  logic [FuncW-1:0]    req_tuser,   // func
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // site_out, site_total, released_size
   output logic [StatW-1:0]    rsp_tuser    // status
);

   cmd_type           cmd;
   sts_type           sts;
   logic [HashW-1:0]  site_out;
   logic [TotalW-1:0] site_total;
   logic [SizeW-1:0]  released_size;

   asat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   asat_dp #(.PTR_ENTRIES(PTR_ENTRIES), .SITE_ENTRIES(SITE_ENTRIES)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_tuser),
      .req_address       (req_tdata[63:0]),
      .req_byte_count    (req_tdata[103:64]),
      .req_site_hash     (req_tdata[167:104]),
      .req_slot_index    (req_tdata[175:168]),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_status        (rsp_tuser),
      .rsp_site_out      (site_out),
      .rsp_site_total    (site_total),
      .rsp_released_size (released_size)
   );

   assign rsp_tdata = {released_size, site_total, site_out};

endmodule

@@ hw/rtl/asat_checker.sv @@
`include "assert_macros.svh"

module asat_checker import asat_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [ReqDataW-1:0] req_tdata,
   input logic [FuncW-1:0]    req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata,
   input logic [StatW-1:0]    rsp_tuser
);

   // Stalled result stays and holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))

   // Clearing pass keeps input closed right after reset
   `ASSERT_PLAIN(a_clear_after_reset, clock, $past(reset), !req_tready)

   // One item in work at a time
   `ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)

   // Unknown release carries an all-zero payload
   `ASSERT_IMPLY(a_unknown_zero, clock, reset, rsp_tvalid && rsp_tuser == STATUS_UNKNOWN, rsp_tdata == '0)

endmodule

bind allocation_site_accounting_table asat_checker u_asat_checker (.*);

@@ tb/tb_allocation_site_accounting_table.sv @@
module tb_allocation_site_accounting_table;
   import asat_pkg::*;

   localparam int  PtrN         = PtrEntriesDefault;
   localparam int  SiteN        = SiteEntriesDefault;
   localparam int  ItemsPerRun  = 650;
   localparam int  HashPool     = 300;
   localparam longint CycleLimit = 12_000_000;
   localparam logic [SizeW-1:0]  SizeMax  = '1;
   localparam logic [TotalW-1:0] TotalMax = '1;
   localparam logic [FuncW-1:0]  FuncUnused = 2'd3;

   typedef struct {
      logic [FuncW-1:0] func;
      logic [AddrW-1:0] address;
      logic [SizeW-1:0] byte_count;
      logic [HashW-1:0] site_hash;
      logic [SlotW-1:0] slot_index;
   } alloc_event_type;

   typedef struct {
      logic [StatW-1:0]  status;
      logic [HashW-1:0]  site_out;
      logic [TotalW-1:0] site_total;
      logic [SizeW-1:0]  released_size;
   } site_report_type;

   // Tracks both tables and the reports still owed by the block
   class site_ledger;
      bit                ptr_live [PtrN];
      logic [AddrW-1:0]  ptr_addr [PtrN];
      logic [SizeW-1:0]  ptr_bytes[PtrN];
      int                ptr_site [PtrN];
      bit                site_live [SiteN];
      logic [HashW-1:0]  site_hash [SiteN];
      logic [TotalW-1:0] site_sum  [SiteN];
      site_report_type   owed[$];
      int                mismatches;

      function int find_ptr(logic [AddrW-1:0] a);
         for (int i = 0; i < PtrN; i++)
            if (ptr_live[i] && ptr_addr[i] == a) return i;
         return -1;
      endfunction

      function int find_site(logic [HashW-1:0] h);
         for (int i = 0; i < SiteN; i++)
            if (site_live[i] && site_hash[i] == h) return i;
         return -1;
      endfunction

      // Predict the report for one accepted event and update the tables
      function void note_item(alloc_event_type ev);
         site_report_type r;
         int p, s, fp, fs;
         logic [TotalW:0] sum;
         r = '{default: '0};
         case (ev.func)
            FUNC_ALLOC: begin
               p = find_ptr(ev.address);
               if (p >= 0) begin
                  r.status     = STATUS_DUP;
                  r.site_out   = site_hash[ptr_site[p]];
                  r.site_total = site_sum[ptr_site[p]];
               end else begin
                  s  = find_site(ev.site_hash);
                  fp = -1;
                  for (int i = PtrN - 1; i >= 0; i--) if (!ptr_live[i]) fp = i;
                  fs = s;
                  if (fs < 0)
                     for (int i = SiteN - 1; i >= 0; i--) if (!site_live[i]) fs = i;
                  if (fp < 0 || fs < 0) begin
                     r.status     = STATUS_FULL;
                     r.site_out   = ev.site_hash;
                     r.site_total = (s >= 0) ? site_sum[s] : '0;
                  end else begin
                     if (s < 0) begin
                        site_live[fs] = 1;
                        site_hash[fs] = ev.site_hash;
                        site_sum[fs]  = '0;
                     end
                     sum = site_sum[fs] + ev.byte_count;
                     site_sum[fs]  = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
                     ptr_live[fp]  = 1;
                     ptr_addr[fp]  = ev.address;
                     ptr_bytes[fp] = ev.byte_count;
                     ptr_site[fp]  = fs;
                     r.status     = STATUS_RECORDED;
                     r.site_out   = ev.site_hash;
                     r.site_total = site_sum[fs];
                  end
               end
            end
            FUNC_FREE: begin
               p = find_ptr(ev.address);
               if (p < 0) begin
                  r.status = STATUS_UNKNOWN;
               end else begin
                  s = ptr_site[p];
                  site_sum[s] = (site_sum[s] > ptr_bytes[p]) ?
                                site_sum[s] - ptr_bytes[p] : '0;
                  ptr_live[p]     = 0;
                  r.status        = STATUS_RELEASED;
                  r.site_out      = site_hash[s];
                  r.site_total    = site_sum[s];
                  r.released_size = ptr_bytes[p];
               end
            end
            FUNC_REPORT: begin
               if (ev.slot_index < SiteN && site_live[ev.slot_index]) begin
                  r.status     = STATUS_VALID;
                  r.site_out   = site_hash[ev.slot_index];
                  r.site_total = site_sum[ev.slot_index];
               end else begin
                  r.status = STATUS_EMPTY;
               end
            end
            default: return;   // unused code: no report
         endcase
         owed.insert(owed.size(), r);
      endfunction

      function void check_result(site_report_type got);
         site_report_type want;
         if (owed.size() == 0) begin
            $error("unexpected result transfer, status %0d", got.status);
            mismatches++;
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.site_out !== want.site_out) begin
            $error("site_out: expected %h, actual %h", want.site_out, got.site_out);
            mismatches++;
         end
         if (got.site_total !== want.site_total) begin
            $error("site_total: expected %h, actual %h", want.site_total, got.site_total);
            mismatches++;
         end
         if (got.released_size !== want.released_size) begin
            $error("released_size: expected %h, actual %h",
                   want.released_size, got.released_size);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic [FuncW-1:0]    req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [StatW-1:0]    rsp_tuser;

   site_ledger       ledger = new();
   int               tx_idle = 16;
   int               rx_idle = 61;
   longint           cycles = 0;
   logic [AddrW-1:0] issued_addrs[$];
   logic [HashW-1:0] hashes[HashPool];

   allocation_site_accounting_table dut (.*);

   initial forever #10 clock = ~clock;

   // Result side: check each transfer, stall at random
   always @(posedge clock) begin
      site_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status        = rsp_tuser;
         got.site_out      = rsp_tdata[63:0];
         got.site_total    = rsp_tdata[111:64];
         got.released_size = rsp_tdata[151:112];
         ledger.check_result(got);
      end
      rsp_tready <= ($urandom_range(99) >= rx_idle);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SizeW-1:0] rand_size();
      return SizeW'({$urandom, $urandom});
   endfunction

   function automatic logic [SlotW-1:0] rand_slot();
      return SlotW'($urandom);
   endfunction

   // One transfer on req, with random idle cycles in front
   task automatic send(logic [FuncW-1:0] f, logic [AddrW-1:0] a,
                       logic [SizeW-1:0] sz, logic [HashW-1:0] h, logic [SlotW-1:0] sl);
      alloc_event_type ev;
      ev = '{func: f, address: a, byte_count: sz, site_hash: h, slot_index: sl};
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= f;
      req_tdata  <= {sl, h, sz, a};
      do @(posedge clock); while (!req_tready);
      ledger.note_item(ev);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (ledger.owed.size() != 0) @(posedge clock);
   endtask

   // Random traffic; alloc_heavy grows the tables toward full
   task automatic random_run(bit alloc_heavy);
      int n, r, k;
      logic [HashW-1:0] h;
      logic [SizeW-1:0] sz;
      n = 0;
      while (n < ItemsPerRun) begin
         r = $urandom_range(99);
         if (!alloc_heavy) r = (r < 30) ? r : r + 10;   // shift mix toward releases
         if (r < 85) begin
            if ($urandom_range(99) < 30) begin
               h  = hashes[0];                      // hot site drives saturation
               sz = SizeMax;
            end else begin
               h  = hashes[$urandom_range(HashPool - 1)];
               sz = ($urandom_range(9) == 0) ? rand_size() :
                    SizeW'($urandom_range(4095));
            end
            issued_addrs.insert(issued_addrs.size(), rand64());
            send(FUNC_ALLOC, issued_addrs[$], sz, h, rand_slot());
         end else if (r < 88 && issued_addrs.size() > 0) begin
            send(FUNC_ALLOC, issued_addrs[$urandom_range(issued_addrs.size() - 1)],
                 rand_size(), rand64(), rand_slot());
         end else if (r < 93 || r >= 100) begin
            if (issued_addrs.size() > 0 && $urandom_range(9) != 0) begin
               k = $urandom_range(issued_addrs.size() - 1);
               send(FUNC_FREE, issued_addrs[k], rand_size(), rand64(), rand_slot());
               issued_addrs.delete(k);
            end else begin
               send(FUNC_FREE, rand64(), rand_size(), rand64(), rand_slot());
            end
         end else if (r < 98) begin
            send(FUNC_REPORT, rand64(), rand_size(), rand64(), rand_slot());
         end else begin
            send(FuncUnused, rand64(), rand_size(), rand64(), rand_slot());
            n--;   // ignored code, not counted
         end
         n++;
      end
   endtask

   initial begin
      logic [63:0] ones;
      ones = '1;
      foreach (hashes[i]) hashes[i] = rand64();
      repeat (7) @(posedge clock);
      reset <= 0;

      // Directed: empty tables, extremes, duplicates, unknown releases, ignored code
      send(FUNC_REPORT, 0, 0, 0, 0);
      send(FUNC_FREE, 0, 0, 0, 0);
      send(FUNC_ALLOC, 0, 0, 0, 0);
      send(FUNC_ALLOC, ones, SizeMax, ones, '1);
      send(FUNC_ALLOC, 0, SizeMax, ones, 0);
      send(FUNC_ALLOC, 5, SizeMax, ones, 0);
      send(FUNC_REPORT, 0, 0, 0, 0);
      send(FUNC_REPORT, 0, 0, 0, 1);
      send(FUNC_REPORT, ones, SizeMax, ones, 2);
      send(FUNC_REPORT, 0, 0, 0, '1);
      send(FuncUnused, 7, SizeMax, ones, 1);
      send(FUNC_FREE, ones, 0, 0, 0);
      send(FUNC_FREE, ones, 0, 0, 0);
      send(FUNC_FREE, 5, 0, 0, 0);
      send(FUNC_REPORT, 0, 0, 0, 1);
      send(FUNC_FREE, 0, 0, 0, 0);
      send(FUNC_ALLOC, 64'h8000_0000_0000_0000, 1, 64'h5555_5555_5555_5555, 0);
      send(FUNC_ALLOC, 64'h8000_0000_0000_0000, 2, 64'h5555_5555_5555_5555, 0);
      send(FUNC_FREE, 64'h8000_0000_0000_0000, 0, 0, 0);
      send(FUNC_REPORT, 0, 0, 0, 2);
      drain();   // sender holds off until every report is back

      tx_idle = 16; rx_idle = 61;
      random_run(1);
      tx_idle = 61; rx_idle = 16;
      random_run(1);
      tx_idle = 0;  rx_idle = 0;
      random_run(0);
      drain();
      repeat (PtrN + SiteN + 20) @(posedge clock);

      if (ledger.mismatches == 0 && ledger.owed.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
